[rtl/sfr_pkg.sv]
// Shared constants and codes for the stuffed frame receiver.
package sfr_pkg;

  // Field widths
  localparam int BYTE_W    = 8;
  localparam int STATUS_W  = 3;
  localparam int LENGTH_W  = 11;
  localparam int CFG_IDX_W = 2;

  // Largest payload accepted before an overflow status is given.
  localparam logic [LENGTH_W-1:0] MAX_PAYLOAD = 11'd1024;

  // Escape transform and sequence bit position in the control byte.
  localparam logic [BYTE_W-1:0] ESC_XOR = 8'h20;
  localparam int                SEQ_POS = 6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FLAG       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCONNECT = 2'd3;

  // Configuration reset values
  localparam logic [BYTE_W-1:0] FLAG_RST       = 8'h7E;
  localparam logic [BYTE_W-1:0] ESCAPE_RST     = 8'h7D;
  localparam logic [BYTE_W-1:0] ADDRESS_RST    = 8'h03;
  localparam logic [BYTE_W-1:0] DISCONNECT_RST = 8'h0B;

  // End-of-frame status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_HEADER_ERR = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BCC2_ERR   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DISCONNECT = 3'd4;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 3'd5;

  // Header verdicts kept while a frame is received
  localparam logic [1:0] VERDICT_OK  = 2'd0;
  localparam logic [1:0] VERDICT_DUP = 2'd1;
  localparam logic [1:0] VERDICT_HDR = 2'd2;

endpackage

[rtl/stuffed_frame_receiver.sv]
// Byte-stuffed frame receiver with XOR block check characters.
// Path: an accepted byte is held in the input register and decoded combinationally; its result
// (if any) is registered in the result register, which drives the out_ channel.
// Throughput: one byte per cycle, limited only by out_ready backpressure.
// Reset: rst_n is synchronous and active low; it restores the default
// configuration, hunts for an opening flag and sets the last sequence bit.
module stuffed_frame_receiver (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration write port
  input  logic                           cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfr_pkg::BYTE_W-1:0]     cfg_data,
  // Raw line bytes
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sfr_pkg::BYTE_W-1:0]     in_rx_byte,
  // Payload bytes and frame status
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_is_status,
  output logic [sfr_pkg::BYTE_W-1:0]     out_payload_byte,
  output logic [sfr_pkg::STATUS_W-1:0]   out_frame_status,
  output logic [sfr_pkg::LENGTH_W-1:0]   out_payload_length,
  output logic                           out_last
);
  import sfr_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_FLAG,
    PH_ADDR,
    PH_ONE,
    PH_HDR,
    PH_DATA
  } phase_t;

  // Configuration registers
  logic [BYTE_W-1:0] flag_r, escape_r, address_r, disconnect_r;

  // Input register
  logic              a_valid_r;
  logic [BYTE_W-1:0] a_byte_r;

  // Frame state
  phase_t              phase_r, phase_nxt;
  logic                esc_r, esc_nxt;
  logic [BYTE_W-1:0]   ctrl_r, ctrl_nxt;
  logic                hdr_seen_r, hdr_seen_nxt;
  logic [1:0]          verdict_r, verdict_nxt;
  logic [BYTE_W-1:0]   held_r, held_nxt;
  logic                held_valid_r, held_valid_nxt;
  logic [BYTE_W-1:0]   xor_r, xor_nxt;
  logic [LENGTH_W-1:0] count_r, count_nxt;
  logic                seq_r, seq_nxt;

  // Result register
  logic                out_valid_r;
  logic                is_status_r;
  logic [BYTE_W-1:0]   pbyte_r;
  logic [STATUS_W-1:0] status_r;
  logic [LENGTH_W-1:0] length_r;

  // Decoded result of the byte in the input register
  logic                res_v, res_is_status;
  logic [BYTE_W-1:0]   res_byte;
  logic [STATUS_W-1:0] res_status;
  logic [LENGTH_W-1:0] res_length;

  logic              advance;
  logic              route;
  logic              take;
  logic [BYTE_W-1:0] b;
  logic [BYTE_W-1:0] d;
  logic [BYTE_W-1:0] expect_ctrl;

  // The input register moves on whenever the result register can take a result.
  assign advance  = a_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !a_valid_r || advance;
  assign b        = a_byte_r;
  assign expect_ctrl = {1'b0, ~seq_r, 6'b0};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r       <= FLAG_RST;
      escape_r     <= ESCAPE_RST;
      address_r    <= ADDRESS_RST;
      disconnect_r <= DISCONNECT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FLAG:       flag_r       <= cfg_data;
        CFG_ESCAPE:     escape_r     <= cfg_data;
        CFG_ADDRESS:    address_r    <= cfg_data;
        CFG_DISCONNECT: disconnect_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_byte_r <= in_rx_byte;
    end
  end

  // Frame decoder: one raw byte per pass
  always_comb begin
    phase_nxt      = phase_r;
    esc_nxt        = esc_r;
    ctrl_nxt       = ctrl_r;
    hdr_seen_nxt   = hdr_seen_r;
    verdict_nxt    = verdict_r;
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    xor_nxt        = xor_r;
    count_nxt      = count_r;
    seq_nxt        = seq_r;
    res_v          = 1'b0;
    res_is_status  = 1'b0;
    res_byte       = '0;
    res_status     = ST_OK;
    res_length     = '0;
    route          = 1'b0;
    take           = 1'b0;
    d              = b;

    // Phase handling ahead of destuffing
    case (phase_r)
      PH_HUNT: begin
        if (b == flag_r) begin
          phase_nxt = PH_FLAG;
        end
      end
      PH_FLAG: begin
        if (b == address_r) begin
          phase_nxt = PH_ADDR;
        end else if (b != flag_r) begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_ADDR: begin
        if (b == disconnect_r) begin
          res_v         = 1'b1;
          res_is_status = 1'b1;
          res_status    = ST_DISCONNECT;
          phase_nxt     = PH_HUNT;
        end else if (b == flag_r) begin
          phase_nxt = PH_FLAG;
        end else begin
          phase_nxt = PH_ONE;
          route     = 1'b1;
        end
      end
      PH_ONE: begin
        if (b == flag_r) begin
          phase_nxt = PH_FLAG;
        end else begin
          phase_nxt = PH_HDR;
          route     = 1'b1;
        end
      end
      PH_HDR, PH_DATA: begin
        if (b == flag_r) begin
          // Closing flag: settle the frame verdict
          res_v         = 1'b1;
          res_is_status = 1'b1;
          res_length    = count_r;
          phase_nxt     = PH_HUNT;
          if (esc_r || phase_r != PH_DATA) begin
            res_status = ST_HEADER_ERR;
          end else if (verdict_r != VERDICT_OK) begin
            res_status = {1'b0, verdict_r};
          end else if (!held_valid_r) begin
            res_status = ST_HEADER_ERR;
          end else if (held_r == xor_r) begin
            res_status = ST_OK;
            seq_nxt    = ~seq_r;
          end else begin
            res_status = ST_BCC2_ERR;
          end
        end else begin
          route = 1'b1;
        end
      end
      default: phase_nxt = PH_HUNT;
    endcase

    // A flag that opens a frame starts it with clean state.
    if (b == flag_r && !res_v &&
        (phase_r == PH_HUNT || phase_r == PH_ADDR || phase_r == PH_ONE)) begin
      esc_nxt        = 1'b0;
      ctrl_nxt       = '0;
      hdr_seen_nxt   = 1'b0;
      verdict_nxt    = VERDICT_OK;
      held_nxt       = '0;
      held_valid_nxt = 1'b0;
      xor_nxt        = '0;
      count_nxt      = '0;
    end

    // Destuffing
    if (route) begin
      if (esc_r) begin
        esc_nxt = 1'b0;
        d       = b ^ ESC_XOR;
        take    = 1'b1;
      end else if (b == escape_r) begin
        esc_nxt = 1'b1;
      end else begin
        take = 1'b1;
      end
    end

    // Route a destuffed byte: control, BCC1, then delayed payload
    if (take) begin
      if (!hdr_seen_r) begin
        ctrl_nxt     = d;
        hdr_seen_nxt = 1'b1;
      end else if (phase_nxt != PH_DATA) begin
        if (ctrl_r[BYTE_W-1:SEQ_POS] == {1'b0, seq_r}) begin
          verdict_nxt = VERDICT_DUP;
        end else if (ctrl_r != expect_ctrl || d != (address_r ^ ctrl_r)) begin
          verdict_nxt = VERDICT_HDR;
        end else begin
          verdict_nxt = VERDICT_OK;
        end
        phase_nxt = PH_DATA;
      end else if (held_valid_r) begin
        if (count_r >= MAX_PAYLOAD) begin
          res_v         = 1'b1;
          res_is_status = 1'b1;
          res_status    = ST_OVERFLOW;
          res_length    = MAX_PAYLOAD;
          phase_nxt     = PH_HUNT;
        end else begin
          count_nxt = count_r + 1'b1;
          xor_nxt   = xor_r ^ held_r;
          held_nxt  = d;
          if (verdict_r == VERDICT_OK) begin
            res_v    = 1'b1;
            res_byte = held_r;
          end
        end
      end else begin
        held_nxt       = d;
        held_valid_nxt = 1'b1;
      end
    end
  end

  // Frame state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      esc_r        <= 1'b0;
      ctrl_r       <= '0;
      hdr_seen_r   <= 1'b0;
      verdict_r    <= VERDICT_OK;
      held_r       <= '0;
      held_valid_r <= 1'b0;
      xor_r        <= '0;
      count_r      <= '0;
      seq_r        <= 1'b1;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      esc_r        <= esc_nxt;
      ctrl_r       <= ctrl_nxt;
      hdr_seen_r   <= hdr_seen_nxt;
      verdict_r    <= verdict_nxt;
      held_r       <= held_nxt;
      held_valid_r <= held_valid_nxt;
      xor_r        <= xor_nxt;
      count_r      <= count_nxt;
      seq_r        <= seq_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_v;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_v) begin
      is_status_r <= res_is_status;
      pbyte_r     <= res_byte;
      status_r    <= res_status;
      length_r    <= res_length;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_is_status      = is_status_r;
  assign out_payload_byte   = pbyte_r;
  assign out_frame_status   = status_r;
  assign out_payload_length = length_r;
  assign out_last           = is_status_r;

endmodule

[rtl/sfr_checker.sv]
// Port-level checks for the stuffed frame receiver, with the bind that attaches them.
module sfr_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_is_status,
  input logic [sfr_pkg::BYTE_W-1:0]    out_payload_byte,
  input logic [sfr_pkg::STATUS_W-1:0]  out_frame_status,
  input logic [sfr_pkg::LENGTH_W-1:0]  out_payload_length,
  input logic                          out_last
);
  import sfr_pkg::*;

  // The end marker goes with status items only.
  a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == out_is_status))
    else $error("out_last differs from out_is_status");

  // Payload items carry no status and no length.
  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_status) |->
      (out_frame_status == ST_OK && out_payload_length == '0))
    else $error("payload item carries status fields");

  // A disconnect never reports a length; overflow reports the limit.
  a_status_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_status) |->
      ((out_frame_status != ST_DISCONNECT || out_payload_length == '0) &&
       (out_frame_status != ST_OVERFLOW || out_payload_length == MAX_PAYLOAD)))
    else $error("status item length is inconsistent");

  // A stalled result item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_is_status) && $stable(out_payload_byte) &&
       $stable(out_frame_status) && $stable(out_payload_length)))
    else $error("result item changed while stalled");

endmodule

bind stuffed_frame_receiver sfr_checker u_sfr_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_is_status      (out_is_status),
  .out_payload_byte   (out_payload_byte),
  .out_frame_status   (out_frame_status),
  .out_payload_length (out_payload_length),
  .out_last           (out_last)
);
